>>> src/bdq_pkg.sv
// Package for the bounded deque: sizes, command and status codes,
// cell control struct and output formatting function. No dependencies.
package bdq_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int IDX_W      = $clog2(CAPACITY);

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [IDX_W-1:0]      idx_type;

   typedef enum logic [2:0] {
      CMD_PUSH_TAIL = 3'd0,
      CMD_PUSH_HEAD = 3'd1,
      CMD_POP_TAIL  = 3'd2,
      CMD_POP_HEAD  = 3'd3,
      CMD_DELETE    = 3'd4,
      CMD_SEARCH    = 3'd5,
      CMD_CLEAR     = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_LOAD_TAIL,
      OP_SHIFT_RIGHT,
      OP_SHIFT_LEFT,
      OP_DELETE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      data_type    key;
   } cell_ctrl_type;

   // sign-extend a stored entry and keep the low 32 bits
   function automatic logic [31:0] to_out32(data_type d);
      logic signed [63:0] ext;
      ext = 64'(signed'(d));
      return ext[31:0];
   endfunction

endpackage

>>> src/bdq_req_if.sv
// Command channel interface of the deque: valid/ready plus the command item.
// Depends on nothing.
interface bdq_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         cmd;
   logic signed [31:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

>>> src/bdq_rsp_if.sv
// Response channel interface of the deque: valid/ready plus the result item.
// Depends on nothing.
interface bdq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic [1:0]         status;
   logic [4:0]         count;

   modport source (output valid, output result_value, output status, output count,
                   input ready);
   modport sink   (input valid, input result_value, input status, input count,
                   output ready);
endinterface

>>> src/bounded_deque_with_delete_top.sv
// Top level of the bounded deque: cell chain, occupancy counter, command
// decode and response register. Depends on bdq_pkg, bdq_req_if, bdq_rsp_if,
// bdq_cell.
//
//   channel   dir  item
//   req_ch    in   cmd, value
//   rsp_ch    out  result_value, status, count
//
// One command per cycle while responses are consumed; its response is registered and shows the next cycle.
// Search and delete compare all slots at once along the cell chain's match line.
// Reset (synchronous) empties the deque and drops any pending response.
// A stalled response holds; a new command is taken in the cycle it is consumed.
module bounded_deque_with_delete_top import bdq_pkg::*; (
   input logic       clock,
   input logic       reset,
   bdq_req_if.sink   req_ch,
   bdq_rsp_if.source rsp_ch
);

   cnt_type     occ_ff, occ_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   status_type  rsp_status_ff, rsp_status_in;
   cnt_type     rsp_count_ff, rsp_count_in;

   logic          accept;
   cmd_type       cmd;
   data_type      key;
   cell_ctrl_type ctrl;
   cell_op_type   op;
   logic          full;
   logic          empty;
   idx_type       tail_idx;

   data_type cell_data  [CAPACITY];
   data_type left_data  [CAPACITY];
   data_type right_data [CAPACITY];
   logic     hit_chain  [CAPACITY+1];

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign cmd          = cmd_type'(req_ch.cmd);
   assign key          = DATA_WIDTH'({32'd0, req_ch.value});
   assign full         = (occ_ff == cnt_type'(CAPACITY));
   assign empty        = (occ_ff == '0);
   assign tail_idx     = IDX_W'(occ_ff - cnt_type'(1));

   assign ctrl.op  = accept ? op : OP_HOLD;
   assign ctrl.key = key;

   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_data[i] = key;
      end else begin : g_mid
         assign left_data[i] = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_data[i] = cell_data[i];
      end else begin : g_inner
         assign right_data[i] = cell_data[i+1];
      end

      bdq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .valid      (cnt_type'(i) < occ_ff),
         .tail_sel   (cnt_type'(i) == occ_ff),
         .left_data  (left_data[i]),
         .right_data (right_data[i]),
         .hit_in     (hit_chain[i]),
         .hit_out    (hit_chain[i+1]),
         .data_out   (cell_data[i])
      );
   end

   always_comb begin
      op            = OP_HOLD;
      occ_in        = occ_ff;
      rsp_value_in  = '0;
      rsp_status_in = ST_OK;
      unique case (cmd)
         CMD_PUSH_TAIL, CMD_PUSH_HEAD: begin
            if (full) begin
               rsp_status_in = ST_FULL;
            end else begin
               op     = (cmd == CMD_PUSH_TAIL) ? OP_LOAD_TAIL : OP_SHIFT_RIGHT;
               occ_in = occ_ff + cnt_type'(1);
            end
         end
         CMD_POP_TAIL: begin
            if (empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_value_in = to_out32(cell_data[tail_idx]);
               occ_in       = occ_ff - cnt_type'(1);
            end
         end
         CMD_POP_HEAD: begin
            if (empty) begin
               rsp_status_in = ST_EMPTY;
            end else begin
               rsp_value_in = to_out32(cell_data[0]);
               op           = OP_SHIFT_LEFT;
               occ_in       = occ_ff - cnt_type'(1);
            end
         end
         CMD_DELETE, CMD_SEARCH: begin
            if (empty) begin
               rsp_status_in = ST_EMPTY;
            end else if (!hit_chain[CAPACITY]) begin
               rsp_status_in = ST_NOT_FOUND;
            end else if (cmd == CMD_DELETE) begin
               op     = OP_DELETE;
               occ_in = occ_ff - cnt_type'(1);
            end
         end
         CMD_CLEAR: occ_in = '0;
         default: ;
      endcase
      rsp_count_in = occ_in;
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_value = rsp_value_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.count        = 5'(rsp_count_ff);

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= cnt_type'(CAPACITY))
      else $error("occupancy above capacity");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff == occ_ff))
      else $error("pending response count differs from occupancy");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> (rsp_count_ff == cnt_type'(CAPACITY)))
      else $error("full status without a full deque");

   a_fail_keeps: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_status_in != ST_OK) |=> $stable(occ_ff))
      else $error("failed command changed occupancy");

endmodule

>>> src/bdq_cell.sv
// One slot of the deque chain: holds an entry, compares it with the key,
// and loads from the key or a neighbor. Depends on bdq_pkg.
module bdq_cell import bdq_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          valid,
   input  logic          tail_sel,
   input  data_type      left_data,
   input  data_type      right_data,
   input  logic          hit_in,
   output logic          hit_out,
   output data_type      data_out
);

   data_type data_ff;
   data_type data_in;

   always_comb begin
      hit_out = hit_in | (valid && (data_ff == ctrl.key));
      data_in = data_ff;
      unique case (ctrl.op)
         OP_HOLD: ;
         OP_LOAD_TAIL: begin
            if (tail_sel) data_in = ctrl.key;
         end
         OP_SHIFT_RIGHT: data_in = left_data;
         OP_SHIFT_LEFT:  data_in = right_data;
         OP_DELETE: begin
            // first match and every slot behind it load from the right neighbor
            if (hit_out) data_in = right_data;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule
